/* design/sgi_pkg.sv */
// ----------------------------------------------------------------------------
// Segment intersection package
// Widths, pipeline types, register indexes and latency figures shared by the
// segment intersection pipeline.
// ----------------------------------------------------------------------------
package sgi_pkg;

  // Coordinate format and derived datapath widths.
  localparam int CW   = 16;           // coordinate width
  localparam int AW   = CW + 1;       // line coefficient a, b
  localparam int CCW  = 2 * CW + 2;   // line constant c
  localparam int DW   = 2 * CW + 3;   // determinant
  localparam int PLW  = 2 * AW + 1;   // coefficient times low half of c
  localparam int NW   = 3 * CW + 4;   // crossing numerators
  localparam int QB   = CW + 1;       // quotient bits produced by the divider
  localparam int PW   = CW + 2;       // crossing point and box bounds
  localparam int EPSW = 16;
  localparam int TOLW = 12;
  localparam int CFG_IW = 8;
  localparam int CFG_DW = 16;

  // Configuration register indexes.
  localparam logic [CFG_IW-1:0] REG_DET_EPS = 8'd0;
  localparam logic [CFG_IW-1:0] REG_BOX_TOL = 8'd1;
  localparam logic [EPSW-1:0]   DET_EPS_RST = 16'd1;
  localparam logic [TOLW-1:0]   BOX_TOL_RST = 12'd3;

  // Largest quotient magnitudes that still fit the coordinate range.
  localparam logic [QB:0] QPOS_MAX = (QB + 1)'((2 ** (CW - 1)) - 1);
  localparam logic [QB:0] QNEG_MAX = (QB + 1)'(2 ** (CW - 1));

  // Pipeline depth: front end, one divider stage per quotient bit, back end.
  localparam int FRONT_LAT = 8;
  localparam int BACK_LAT  = 3;
  localparam int LAT       = FRONT_LAT + QB + BACK_LAT;

  typedef struct packed {
    logic signed [CW-1:0] sx1;
    logic signed [CW-1:0] sy1;
    logic signed [CW-1:0] ex1;
    logic signed [CW-1:0] ey1;
    logic signed [CW-1:0] sx2;
    logic signed [CW-1:0] sy2;
    logic signed [CW-1:0] ex2;
    logic signed [CW-1:0] ey2;
  } seg_t;

  typedef struct packed {
    logic signed [PW-1:0] lox1;
    logic signed [PW-1:0] hix1;
    logic signed [PW-1:0] loy1;
    logic signed [PW-1:0] hiy1;
    logic signed [PW-1:0] lox2;
    logic signed [PW-1:0] hix2;
    logic signed [PW-1:0] loy2;
    logic signed [PW-1:0] hiy2;
  } box_t;

  typedef struct packed {
    box_t box;
    logic par;
    logic negx;
    logic negy;
    logic ovfx;
    logic ovfy;
  } side_t;

  typedef struct packed {
    logic [NW-1:0] nx;
    logic [NW-1:0] ny;
    logic [DW-1:0] d;
    side_t         side;
  } div_in_t;

  typedef struct packed {
    logic [QB-1:0] qx;
    logic [QB-1:0] qy;
    logic [DW-1:0] rx;
    logic [DW-1:0] ry;
    logic [DW-1:0] d;
    side_t         side;
  } div_out_t;

  typedef struct packed {
    logic          hit;
    logic [CW-1:0] x;
    logic [CW-1:0] y;
  } res_t;

endpackage

/* design/sgi_if.sv */
// ----------------------------------------------------------------------------
// Segment intersection channel interfaces
// Valid/ready channels for segment requests, results and register writes.
// ----------------------------------------------------------------------------
interface sgi_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] first_start_x;
  logic [15:0] first_start_y;
  logic [15:0] first_end_x;
  logic [15:0] first_end_y;
  logic [15:0] second_start_x;
  logic [15:0] second_start_y;
  logic [15:0] second_end_x;
  logic [15:0] second_end_y;

  modport source (output valid, first_start_x, first_start_y, first_end_x, first_end_y,
                  second_start_x, second_start_y, second_end_x, second_end_y,
                  input ready);
  modport sink (input valid, first_start_x, first_start_y, first_end_x, first_end_y,
                second_start_x, second_start_y, second_end_x, second_end_y,
                output ready);
endinterface

interface sgi_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [15:0] cross_x;
  logic [15:0] cross_y;

  modport source (output valid, hit, cross_x, cross_y, input ready);
  modport sink (input valid, hit, cross_x, cross_y, output ready);
endinterface

interface sgi_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* design/sgi_front.sv */
// ----------------------------------------------------------------------------
// Segment intersection front end
// Eight stages: line coefficients, line constants, determinant, crossing
// numerators, magnitudes and the quotient overflow test.
// ----------------------------------------------------------------------------
module sgi_front (
  input  logic                        clk,
  input  logic                        en,
  input  sgi_pkg::seg_t               seg,
  input  logic [sgi_pkg::EPSW-1:0]    eps,
  input  logic [sgi_pkg::TOLW-1:0]    tol,
  output sgi_pkg::div_in_t            dout
);
  import sgi_pkg::*;

  seg_t s1_r;
  logic signed [AW-1:0] a1_1_r, b1_1_r, a2_1_r, b2_1_r;

  logic signed [CCW-2:0] asx1_r, bsy1_r, asx2_r, bsy2_r;
  logic signed [CCW-1:0] a1b2_r, a2b1_r;
  logic signed [AW-1:0]  a1_2_r, b1_2_r, a2_2_r, b2_2_r;
  box_t                  box2_r;
  logic signed [PW-1:0]  tol_s;

  logic signed [CCW-1:0] c1_r, c2_r;
  logic signed [DW-1:0]  det_r;
  logic signed [AW-1:0]  a1_3_r, b1_3_r, a2_3_r, b2_3_r;
  box_t                  box3_r;

  logic signed [2*AW-1:0] b2c1h_r, b1c2h_r, a1c2h_r, a2c1h_r;
  logic signed [PLW-1:0]  b2c1l_r, b1c2l_r, a1c2l_r, a2c1l_r;
  logic [DW-1:0]          dmag4_r;
  logic                   dneg4_r;
  box_t                   box4_r;

  logic signed [NW-2:0] pb2c1_r, pb1c2_r, pa1c2_r, pa2c1_r;
  logic [DW-1:0]        dmag5_r;
  logic                 dneg5_r, par5_r;
  box_t                 box5_r;

  logic signed [NW-1:0] numx_r, numy_r;
  logic [DW-1:0]        dmag6_r;
  logic                 dneg6_r, par6_r;
  box_t                 box6_r;

  logic [NW-1:0] nx7_r, ny7_r;
  logic [DW-1:0] dmag7_r;
  logic          negx7_r, negy7_r, par7_r;
  box_t          box7_r;

  div_in_t out_r;

  assign tol_s = $signed({{(PW - TOLW){1'b0}}, tol});

  // Stage 1: line coefficients of both segments.
  always_ff @(posedge clk) begin
    if (en) begin
      s1_r   <= seg;
      a1_1_r <= AW'(seg.ey1) - AW'(seg.sy1);
      b1_1_r <= AW'(seg.sx1) - AW'(seg.ex1);
      a2_1_r <= AW'(seg.ey2) - AW'(seg.sy2);
      b2_1_r <= AW'(seg.sx2) - AW'(seg.ex2);
    end
  end

  // Stage 2: products for c and the determinant, widened bounding boxes.
  always_ff @(posedge clk) begin
    if (en) begin
      asx1_r <= a1_1_r * s1_r.sx1;
      bsy1_r <= b1_1_r * s1_r.sy1;
      asx2_r <= a2_1_r * s1_r.sx2;
      bsy2_r <= b2_1_r * s1_r.sy2;
      a1b2_r <= a1_1_r * b2_1_r;
      a2b1_r <= a2_1_r * b1_1_r;
      a1_2_r <= a1_1_r;
      b1_2_r <= b1_1_r;
      a2_2_r <= a2_1_r;
      b2_2_r <= b2_1_r;
      box2_r.lox1 <= PW'((s1_r.sx1 < s1_r.ex1) ? s1_r.sx1 : s1_r.ex1) - tol_s;
      box2_r.hix1 <= PW'((s1_r.sx1 < s1_r.ex1) ? s1_r.ex1 : s1_r.sx1) + tol_s;
      box2_r.loy1 <= PW'((s1_r.sy1 < s1_r.ey1) ? s1_r.sy1 : s1_r.ey1) - tol_s;
      box2_r.hiy1 <= PW'((s1_r.sy1 < s1_r.ey1) ? s1_r.ey1 : s1_r.sy1) + tol_s;
      box2_r.lox2 <= PW'((s1_r.sx2 < s1_r.ex2) ? s1_r.sx2 : s1_r.ex2) - tol_s;
      box2_r.hix2 <= PW'((s1_r.sx2 < s1_r.ex2) ? s1_r.ex2 : s1_r.sx2) + tol_s;
      box2_r.loy2 <= PW'((s1_r.sy2 < s1_r.ey2) ? s1_r.sy2 : s1_r.ey2) - tol_s;
      box2_r.hiy2 <= PW'((s1_r.sy2 < s1_r.ey2) ? s1_r.ey2 : s1_r.sy2) + tol_s;
    end
  end

  // Stage 3: line constants and determinant.
  always_ff @(posedge clk) begin
    if (en) begin
      c1_r   <= CCW'(asx1_r) + CCW'(bsy1_r);
      c2_r   <= CCW'(asx2_r) + CCW'(bsy2_r);
      det_r  <= DW'(a1b2_r) - DW'(a2b1_r);
      a1_3_r <= a1_2_r;
      b1_3_r <= b1_2_r;
      a2_3_r <= a2_2_r;
      b2_3_r <= b2_2_r;
      box3_r <= box2_r;
    end
  end

  // Stage 4: partial products against the high and low halves of c.
  always_ff @(posedge clk) begin
    if (en) begin
      b2c1h_r <= b2_3_r * $signed(c1_r[CCW-1:AW]);
      b1c2h_r <= b1_3_r * $signed(c2_r[CCW-1:AW]);
      a1c2h_r <= a1_3_r * $signed(c2_r[CCW-1:AW]);
      a2c1h_r <= a2_3_r * $signed(c1_r[CCW-1:AW]);
      b2c1l_r <= b2_3_r * $signed({1'b0, c1_r[AW-1:0]});
      b1c2l_r <= b1_3_r * $signed({1'b0, c2_r[AW-1:0]});
      a1c2l_r <= a1_3_r * $signed({1'b0, c2_r[AW-1:0]});
      a2c1l_r <= a2_3_r * $signed({1'b0, c1_r[AW-1:0]});
      dmag4_r <= det_r[DW-1] ? DW'(-det_r) : DW'(det_r);
      dneg4_r <= det_r[DW-1];
      box4_r  <= box3_r;
    end
  end

  // Stage 5: recombine the partial products, parallel test.
  always_ff @(posedge clk) begin
    if (en) begin
      pb2c1_r <= ((NW - 1)'(b2c1h_r) <<< AW) + (NW - 1)'(b2c1l_r);
      pb1c2_r <= ((NW - 1)'(b1c2h_r) <<< AW) + (NW - 1)'(b1c2l_r);
      pa1c2_r <= ((NW - 1)'(a1c2h_r) <<< AW) + (NW - 1)'(a1c2l_r);
      pa2c1_r <= ((NW - 1)'(a2c1h_r) <<< AW) + (NW - 1)'(a2c1l_r);
      dmag5_r <= dmag4_r;
      dneg5_r <= dneg4_r;
      par5_r  <= (dmag4_r <= DW'(eps));
      box5_r  <= box4_r;
    end
  end

  // Stage 6: crossing numerators.
  always_ff @(posedge clk) begin
    if (en) begin
      numx_r  <= NW'(pb2c1_r) - NW'(pb1c2_r);
      numy_r  <= NW'(pa1c2_r) - NW'(pa2c1_r);
      dmag6_r <= dmag5_r;
      dneg6_r <= dneg5_r;
      par6_r  <= par5_r;
      box6_r  <= box5_r;
    end
  end

  // Stage 7: numerator magnitudes and quotient signs.
  always_ff @(posedge clk) begin
    if (en) begin
      nx7_r   <= numx_r[NW-1] ? NW'(-numx_r) : NW'(numx_r);
      ny7_r   <= numy_r[NW-1] ? NW'(-numy_r) : NW'(numy_r);
      negx7_r <= numx_r[NW-1] ^ dneg6_r;
      negy7_r <= numy_r[NW-1] ^ dneg6_r;
      dmag7_r <= dmag6_r;
      par7_r  <= par6_r;
      box7_r  <= box6_r;
    end
  end

  // Stage 8: a quotient of 2^QB or more can never fit, so flag it here.
  always_ff @(posedge clk) begin
    if (en) begin
      out_r.nx        <= nx7_r;
      out_r.ny        <= ny7_r;
      out_r.d         <= dmag7_r;
      out_r.side.box  <= box7_r;
      out_r.side.par  <= par7_r;
      out_r.side.negx <= negx7_r;
      out_r.side.negy <= negy7_r;
      out_r.side.ovfx <= (nx7_r >= {dmag7_r, {QB{1'b0}}});
      out_r.side.ovfy <= (ny7_r >= {dmag7_r, {QB{1'b0}}});
    end
  end

  assign dout = out_r;

endmodule

/* design/sgi_div.sv */
// ----------------------------------------------------------------------------
// Segment intersection divider
// Restoring division of both numerators by the determinant magnitude, one
// quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module sgi_div (
  input  logic               clk,
  input  logic               en,
  input  sgi_pkg::div_in_t   din,
  output sgi_pkg::div_out_t  dout
);
  import sgi_pkg::*;

  logic [NW-1:0] rx_w [QB+1];
  logic [NW-1:0] ry_w [QB+1];
  logic [QB-1:0] qx_w [QB+1];
  logic [QB-1:0] qy_w [QB+1];
  logic [DW-1:0] d_w  [QB+1];
  side_t         sd_w [QB+1];

  assign rx_w[0] = din.nx;
  assign ry_w[0] = din.ny;
  assign qx_w[0] = '0;
  assign qy_w[0] = '0;
  assign d_w[0]  = din.d;
  assign sd_w[0] = din.side;

  // One stage per quotient bit, most significant first.
  for (genvar k = 0; k < QB; k++) begin : g_stage
    localparam int SH = QB - 1 - k;
    logic [NW-1:0] dsh;
    logic          gex, gey;
    logic [NW-1:0] rx_r, ry_r;
    logic [QB-1:0] qx_r, qy_r;
    logic [DW-1:0] d_r;
    side_t         sd_r;

    assign dsh = NW'(d_w[k]) << SH;
    assign gex = (rx_w[k] >= dsh);
    assign gey = (ry_w[k] >= dsh);

    always_ff @(posedge clk) begin
      if (en) begin
        rx_r <= gex ? rx_w[k] - dsh : rx_w[k];
        ry_r <= gey ? ry_w[k] - dsh : ry_w[k];
        qx_r <= {qx_w[k][QB-2:0], gex};
        qy_r <= {qy_w[k][QB-2:0], gey};
        d_r  <= d_w[k];
        sd_r <= sd_w[k];
      end
    end

    assign rx_w[k+1] = rx_r;
    assign ry_w[k+1] = ry_r;
    assign qx_w[k+1] = qx_r;
    assign qy_w[k+1] = qy_r;
    assign d_w[k+1]  = d_r;
    assign sd_w[k+1] = sd_r;
  end

  // The final remainder is below the divisor, so it fits the divisor width.
  assign dout.qx   = qx_w[QB];
  assign dout.qy   = qy_w[QB];
  assign dout.rx   = rx_w[QB][DW-1:0];
  assign dout.ry   = ry_w[QB][DW-1:0];
  assign dout.d    = d_w[QB];
  assign dout.side = sd_w[QB];

endmodule

/* design/sgi_back.sv */
// ----------------------------------------------------------------------------
// Segment intersection back end
// Rounds the quotients, applies sign and range checks, and tests the point
// against both widened bounding boxes.
// ----------------------------------------------------------------------------
module sgi_back (
  input  logic               clk,
  input  logic               en,
  input  sgi_pkg::div_out_t  din,
  output sgi_pkg::res_t      res
);
  import sgi_pkg::*;

  logic [QB:0]          mx_r, my_r;
  side_t                sd1_r;
  logic signed [PW-1:0] px_r, py_r;
  logic                 ok_r;
  box_t                 box2_r;
  res_t                 res_r;
  logic                 inb;

  // Stage 1: round to nearest, ties away from zero.
  always_ff @(posedge clk) begin
    if (en) begin
      mx_r  <= {1'b0, din.qx} + (QB + 1)'(din.rx >= din.d - din.rx);
      my_r  <= {1'b0, din.qy} + (QB + 1)'(din.ry >= din.d - din.ry);
      sd1_r <= din.side;
    end
  end

  // Stage 2: apply the sign and check the coordinate range.
  always_ff @(posedge clk) begin
    if (en) begin
      px_r   <= sd1_r.negx ? -$signed(mx_r) : $signed(mx_r);
      py_r   <= sd1_r.negy ? -$signed(my_r) : $signed(my_r);
      ok_r   <= !sd1_r.par && !sd1_r.ovfx && !sd1_r.ovfy &&
                (sd1_r.negx ? (mx_r <= QNEG_MAX) : (mx_r <= QPOS_MAX)) &&
                (sd1_r.negy ? (my_r <= QNEG_MAX) : (my_r <= QPOS_MAX));
      box2_r <= sd1_r.box;
    end
  end

  // Stage 3: bounding box test and result register.
  assign inb = (px_r >= box2_r.lox1) && (px_r <= box2_r.hix1) &&
               (py_r >= box2_r.loy1) && (py_r <= box2_r.hiy1) &&
               (px_r >= box2_r.lox2) && (px_r <= box2_r.hix2) &&
               (py_r >= box2_r.loy2) && (py_r <= box2_r.hiy2);

  always_ff @(posedge clk) begin
    if (en) begin
      res_r.hit <= ok_r && inb;
      res_r.x   <= (ok_r && inb) ? px_r[CW-1:0] : '0;
      res_r.y   <= (ok_r && inb) ? py_r[CW-1:0] : '0;
    end
  end

  assign res = res_r;

endmodule

/* design/segment_intersection_2d_unit.sv */
// Pipeline: 8 front-end stages, 17 divider stages at one quotient bit each
// and 3 back-end stages lie between an accepted request and its result.
// Throughput: one request per cycle; the whole pipeline holds while a result
// waits at the output, and flows again as soon as it is taken.
// Reset (synchronous, active low) empties the pipeline and sets the
// determinant threshold to 1 and the box margin to 3.
// ----------------------------------------------------------------------------
// Segment intersection unit
// Crossing test of two 2D segments in signed Q8.8 by Cramer's rule.
// ----------------------------------------------------------------------------
module segment_intersection_2d_unit (
  input  logic        clk,
  input  logic        rst_n,
  sgi_in_if.sink      in_ch,
  sgi_out_if.source   out_ch,
  sgi_cfg_if.sink     cfg_ch
);
  import sgi_pkg::*;

  logic [LAT-1:0]  vld_r;
  logic            adv;
  logic [EPSW-1:0] eps_r;
  logic [TOLW-1:0] tol_r;
  seg_t            seg;
  div_in_t         front_out;
  div_out_t        div_out;
  res_t            res;

  // The pipeline advances unless a finished result is being held.
  assign adv         = !vld_r[LAT-1] || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_ch.valid};
    end
  end

  // Register writes are always accepted.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= DET_EPS_RST;
      tol_r <= BOX_TOL_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_DET_EPS: eps_r <= cfg_ch.data[EPSW-1:0];
        REG_BOX_TOL: tol_r <= cfg_ch.data[TOLW-1:0];
        default: ;
      endcase
    end
  end

  assign seg.sx1 = in_ch.first_start_x;
  assign seg.sy1 = in_ch.first_start_y;
  assign seg.ex1 = in_ch.first_end_x;
  assign seg.ey1 = in_ch.first_end_y;
  assign seg.sx2 = in_ch.second_start_x;
  assign seg.sy2 = in_ch.second_start_y;
  assign seg.ex2 = in_ch.second_end_x;
  assign seg.ey2 = in_ch.second_end_y;

  sgi_front u_front (
    .clk  (clk),
    .en   (adv),
    .seg  (seg),
    .eps  (eps_r),
    .tol  (tol_r),
    .dout (front_out)
  );

  sgi_div u_div (
    .clk  (clk),
    .en   (adv),
    .din  (front_out),
    .dout (div_out)
  );

  sgi_back u_back (
    .clk (clk),
    .en  (adv),
    .din (div_out),
    .res (res)
  );

  assign out_ch.valid   = vld_r[LAT-1];
  assign out_ch.hit     = res.hit;
  assign out_ch.cross_x = res.x;
  assign out_ch.cross_y = res.y;

endmodule

/* design/sgi_checker.sv */
// ----------------------------------------------------------------------------
// Segment intersection port checker
// Watches the top-level ports of the unit over time.
// ----------------------------------------------------------------------------
module sgi_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_hit,
  input logic [15:0] out_x,
  input logic [15:0] out_y,
  input logic        cfg_ready
);

  // A held result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A miss always reports the origin.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_x == 16'd0 && out_y == 16'd0)
    else $error("miss with nonzero point");

  // With no result waiting, a new request is always taken.
  a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // Register writes never stall.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("register write stalled");

  // A held result keeps its payload until it is taken.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_hit) && $stable(out_x) && $stable(out_y))
    else $error("result changed while stalled");

endmodule

bind segment_intersection_2d_unit sgi_checker u_sgi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_hit   (out_ch.hit),
  .out_x     (out_ch.cross_x),
  .out_y     (out_ch.cross_y),
  .cfg_ready (cfg_ch.ready)
);
